/* sv/ambp_pkg.sv */
// Shared types and constants for the alpha-to-mono bit packer.
package ambp_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 1024;
  localparam int ROW_WIDTH_W       = 11;
  localparam int THRESHOLD_W       = 8;
  localparam int CFG_INDEX_W       = 8;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = CFG_INDEX_W'(1);

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(1);
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = THRESHOLD_W'(95);

  typedef struct packed {
    logic [7:0] data;
    logic       row_end;
    logic       pad;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/ambp_front.sv */
// Front end: thresholds pixels, packs bits, and classifies finished bytes.
module ambp_front import ambp_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ROW_WIDTH_W-1:0] row_width,
  input  logic [THRESHOLD_W-1:0] threshold,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  logic [7:0]             alpha,
  input  q_status_t              q_status,
  output logic                   q_push,
  output q_entry_t               q_wdata
);

  localparam int CW  = $clog2(MAX_ROW_WIDTH);
  localparam int MWW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int WW  = (MWW > ROW_WIDTH_W) ? MWW : ROW_WIDTH_W;

  logic [CW-1:0] column;
  logic [CW-1:0] column_next;
  logic [7:0]    bit_accumulator;
  logic [7:0]    bit_accumulator_next;

  logic [WW-1:0] rw_ext;
  logic [WW-1:0] max_w;
  logic [WW-1:0] eff_w;
  logic [WW:0]   col_ext;
  logic [2:0]    pos;
  logic          last;
  logic          emit;
  logic          pad;
  logic          accept;
  logic [7:0]    byte_val;

  assign pixel_ready = !q_status.full;
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    rw_ext  = WW'(row_width);
    max_w   = WW'(MAX_ROW_WIDTH);
    if (rw_ext == '0) begin
      eff_w = WW'(1);
    end else if (rw_ext > max_w) begin
      eff_w = max_w;
    end else begin
      eff_w = rw_ext;
    end
    col_ext  = (WW + 1)'(column);
    pos      = col_ext[2:0];
    last     = (col_ext + (WW + 1)'(1)) >= {1'b0, eff_w};
    emit     = (pos == 3'd7) || last;
    pad      = last && !col_ext[3];
    byte_val = bit_accumulator | ((alpha > threshold) ? (8'h80 >> pos) : 8'h00);
    bit_accumulator_next = emit ? 8'h00 : byte_val;
    column_next = last ? '0 : CW'(col_ext + (WW + 1)'(1));
  end

  assign q_push          = accept && emit;
  assign q_wdata.data    = byte_val;
  assign q_wdata.row_end = last && !pad;
  assign q_wdata.pad     = pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      bit_accumulator <= '0;
    end else if (accept) begin
      column          <= column_next;
      bit_accumulator <= bit_accumulator_next;
    end
  end

endmodule

/* sv/ambp_queue.sv */
// Short queue of classified bytes between front and back ends.
module ambp_queue import ambp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  wdata,
  input  logic      pop,
  output q_entry_t  rdata,
  output q_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t      mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign status.full  = (count == NW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign rdata        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty)) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* sv/ambp_back.sv */
// Back end: drives the output register and inserts row padding bytes.
module ambp_back import ambp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  q_rdata,
  input  q_status_t q_status,
  output logic      q_pop,
  output logic      byte_valid,
  input  logic      byte_ready,
  output logic [7:0] packed_byte,
  output logic      row_end
);

  logic pad_pending;
  logic slot_free;

  assign slot_free = !byte_valid || byte_ready;
  assign q_pop     = slot_free && !pad_pending && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      pad_pending <= 1'b0;
    end else if (slot_free) begin
      if (pad_pending) begin
        byte_valid  <= 1'b1;
        pad_pending <= 1'b0;
      end else begin
        byte_valid  <= !q_status.empty;
        pad_pending <= !q_status.empty && q_rdata.pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pad_pending) begin
        packed_byte <= 8'h00;
        row_end     <= 1'b1;
      end else begin
        packed_byte <= q_rdata.data;
        row_end     <= q_rdata.row_end;
      end
    end
  end

  a_pad_follows_data: assert property (@(posedge clk) disable iff (rst)
    pad_pending |-> byte_valid && !row_end) else $error("pad pending without data byte");
  a_pad_byte: assert property (@(posedge clk) disable iff (rst)
    pad_pending && byte_ready |=> byte_valid && row_end && packed_byte == 8'h00)
    else $error("padding byte malformed");
  a_no_pop_on_pad: assert property (@(posedge clk) disable iff (rst)
    pad_pending |-> !q_pop) else $error("pop during padding");

endmodule

/* sv/alpha_to_mono_bit_packer.sv */
// Top level of the alpha-to-mono bit packer: config registers and front/queue/back.
// Path: a byte completed by an accepted pixel is written into the queue and then
//   registered into the output register; its padding byte follows it on the output.
// Throughput: one pixel per cycle while the queue is not full; a padded row end adds
//   a padding byte, absorbed by the four-entry queue; one-pixel rows give two bytes per pixel.
// Reset: rst clears position and accumulator, sets row_width to 1 and threshold to 95.
module alpha_to_mono_bit_packer import ambp_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_WIDTH_W-1:0] cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  logic [7:0]             alpha,
  output logic                   byte_valid,
  input  logic                   byte_ready,
  output logic [7:0]             packed_byte,
  output logic                   row_end
);

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [THRESHOLD_W-1:0] threshold;
  logic                   q_push;
  logic                   q_pop;
  q_entry_t               q_wdata;
  q_entry_t               q_rdata;
  q_status_t              q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_WIDTH) begin
        row_width <= cfg_data;
      end else if (cfg_index == REG_THRESHOLD) begin
        threshold <= cfg_data[THRESHOLD_W-1:0];
      end
    end
  end

  ambp_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .row_width  (row_width),
    .threshold  (threshold),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .alpha      (alpha),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  ambp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  ambp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rdata    (q_rdata),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .packed_byte(packed_byte),
    .row_end    (row_end)
  );

endmodule
